// ===== hw/rtl/jts_pkg.sv =====
// jts_pkg: shared types and constants of the json token scanner
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package jts_pkg;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_ERROR   = 4'd1,
    KIND_DELIM   = 4'd2,
    KIND_SBYTE   = 4'd3,
    KIND_SEND    = 4'd4,
    KIND_INT     = 4'd5,
    KIND_FLOAT   = 4'd6,
    KIND_TRUE    = 4'd7,
    KIND_FALSE   = 4'd8,
    KIND_NULL    = 4'd9
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_STRING  = 4'd1,
    MODE_INT     = 4'd2,
    MODE_FRAC    = 4'd3,
    MODE_EXPSIGN = 4'd4,
    MODE_EXPDIG  = 4'd5,
    MODE_KW_TRUE = 4'd6,
    MODE_KW_FALSE = 4'd7,
    MODE_KW_NULL = 4'd8,
    MODE_ERROR   = 4'd9
  } mode_t;

  localparam logic [62:0] MAG_MAX = {63{1'b1}};
  localparam logic [9:0]  EXP_MAX = 10'd999;
  localparam logic [4:0]  FRAC_MAX = 5'd31;
  localparam logic [15:0] COL_MAX = 16'hFFFF;
  localparam logic [7:0]  CH_NL = 8'h0A;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  delim;
    logic [63:0] value;
    logic [4:0]  frac;
    logic [10:0] expo;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
    logic        ovf;
  } token_t;

  function automatic logic [7:0] kw_char(input logic [3:0] mode, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (mode)
      MODE_KW_TRUE: begin
        unique case (pos)
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      MODE_KW_FALSE: begin
        unique case (pos)
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      MODE_KW_NULL: begin
        unique case (pos)
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/jts_out_queue.sv =====
// jts_out_queue: four-entry token queue between the scanner and the output port
// depends on jts_pkg
`timescale 1ns / 1ps
`default_nettype none
module jts_out_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push0,
  input  wire logic            push1,
  input  wire jts_pkg::token_t tok0,
  input  wire jts_pkg::token_t tok1,
  output logic                 room,
  output logic                 out_valid,
  output jts_pkg::token_t      out_tok,
  input  wire logic            out_ready
);
  import jts_pkg::*;

  token_t     mem [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] npush;

  assign pop = out_valid && out_ready;
  assign npush = {2'b00, push0} + {2'b00, push1};
  assign out_valid = count != 3'd0;
  assign out_tok = mem[rd_ptr];
  // two free entries beside the tokens in flight leave space for one more beat
  assign room = (count + npush) <= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push0 && push1) begin
        mem[wr_ptr] <= tok0;
        mem[wr_ptr + 2'd1] <= tok1;
      end else if (push0) begin
        mem[wr_ptr] <= tok0;
      end else if (push1) begin
        mem[wr_ptr] <= tok1;
      end
      wr_ptr <= wr_ptr + npush[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + npush - {2'b00, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/jts_scan_core.sv =====
// jts_scan_core: per-byte scanner state and token generation
// depends on jts_pkg
`timescale 1ns / 1ps
`default_nettype none
module jts_scan_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      b,
  input  wire logic            eoi,
  output logic                 push0,
  output logic                 push1,
  output jts_pkg::token_t      tok0,
  output jts_pkg::token_t      tok1
);
  import jts_pkg::*;

  logic [3:0]  mode, mode_next;
  logic [62:0] acc, acc_next;
  logic        neg, neg_next;
  logic        sat, sat_next;
  logic [4:0]  frac, frac_next;
  logic [9:0]  expa, expa_next;
  logic        eneg, eneg_next;
  logic [2:0]  kpos, kpos_next;
  logic        esc, esc_next;
  logic [15:0] line, line_next;
  logic [15:0] col, col_next;
  logic [15:0] tcol, tcol_next;

  logic        p0, p1;
  token_t      t0, t1;

  logic        digit;
  logic [3:0]  d;
  logic [62:0] acc_dig;
  logic        acc_ovf;
  logic [9:0]  exp_dig;
  logic [15:0] col_inc;
  token_t      num_tok;
  logic [63:0] sval;
  logic [10:0] sexp;
  logic [66:0] prod;
  logic [13:0] eprod;

  assign digit = b >= "0" && b <= "9";
  assign d = digit ? 4'(b - "0") : 4'd0;
  // acc*10+d fits in 63 bits unless it exceeds MAG_MAX
  assign prod = {4'd0, acc} * 67'd10 + {63'd0, d};
  assign acc_ovf = prod > {4'd0, MAG_MAX};
  assign acc_dig = acc_ovf ? MAG_MAX : prod[62:0];
  assign eprod = {4'd0, expa} * 14'd10 + {10'd0, d};
  assign exp_dig = eprod > {4'd0, EXP_MAX} ? EXP_MAX : eprod[9:0];
  assign col_inc = col < COL_MAX ? col + 16'd1 : col;
  assign sval = neg ? 64'd0 - {1'b0, acc} : {1'b0, acc};
  assign sexp = eneg ? 11'd0 - {1'b0, expa} : {1'b0, expa};

  function automatic token_t simple(input logic [3:0] k, input logic [15:0] c,
                                    input logic [15:0] l);
    token_t t;
    t = '0;
    t.kind = k;
    t.col = c;
    t.line = l;
    return t;
  endfunction

  always_comb begin
    num_tok = simple(mode == MODE_INT ? KIND_INT : KIND_FLOAT, tcol, line);
    num_tok.value = sval;
    num_tok.ovf = sat;
    if (mode != MODE_INT) begin
      num_tok.frac = frac;
      num_tok.expo = sexp;
    end
  end

  always_comb begin
    logic idle_go;
    logic finish;
    idle_go = 1'b0;
    finish = 1'b0;
    mode_next = mode;
    acc_next = acc;
    neg_next = neg;
    sat_next = sat;
    frac_next = frac;
    expa_next = expa;
    eneg_next = eneg;
    kpos_next = kpos;
    esc_next = esc;
    line_next = line;
    col_next = col;
    tcol_next = tcol;
    p0 = 1'b0;
    p1 = 1'b0;
    t0 = '0;
    t1 = '0;

    if (eoi) begin
      if (mode >= MODE_INT && mode <= MODE_EXPDIG) begin
        p0 = 1'b1;
        t0 = num_tok;
      end else if (mode != MODE_IDLE && mode != MODE_ERROR) begin
        p0 = 1'b1;
        t0 = simple(KIND_ERROR, col, line);
      end
      finish = 1'b1;
    end else begin
      priority case (mode)
        MODE_STRING: begin
          if (esc) begin
            esc_next = 1'b0;
            p0 = 1'b1;
            t0 = simple(KIND_SBYTE, tcol, line);
            t0.ch = b;
            col_next = col_inc;
          end else if (b == CH_QUOTE) begin
            p0 = 1'b1;
            t0 = simple(KIND_SEND, tcol, line);
            mode_next = MODE_IDLE;
            col_next = col_inc;
          end else if (b == CH_NL || b == 8'd0) begin
            p0 = 1'b1;
            t0 = simple(KIND_ERROR, col, line);
            mode_next = MODE_ERROR;
          end else begin
            if (b == CH_BSLASH) esc_next = 1'b1;
            p0 = 1'b1;
            t0 = simple(KIND_SBYTE, tcol, line);
            t0.ch = b;
            col_next = col_inc;
          end
        end
        MODE_KW_TRUE, MODE_KW_FALSE, MODE_KW_NULL: begin
          logic [2:0] len;
          logic [3:0] k;
          len = mode == MODE_KW_FALSE ? 3'd5 : 3'd4;
          k = mode == MODE_KW_TRUE ? KIND_TRUE :
              mode == MODE_KW_FALSE ? KIND_FALSE : KIND_NULL;
          if (kpos < len && b == kw_char(mode, kpos)) begin
            kpos_next = kpos + 3'd1;
            col_next = col_inc;
            if (kpos + 3'd1 >= len) begin
              p0 = 1'b1;
              t0 = simple(k, tcol, line);
              mode_next = MODE_IDLE;
              kpos_next = 3'd0;
            end
          end else begin
            p0 = 1'b1;
            t0 = simple(KIND_ERROR, col, line);
            mode_next = MODE_ERROR;
            kpos_next = 3'd0;
            if (b == 8'd0) begin
              p1 = 1'b1;
              t1 = simple(KIND_END, col, line);
              finish = 1'b1;
            end
          end
        end
        MODE_ERROR: begin
          if (b == 8'd0) begin
            p0 = 1'b1;
            t0 = simple(KIND_END, col, line);
            finish = 1'b1;
          end
        end
        MODE_INT, MODE_FRAC, MODE_EXPSIGN, MODE_EXPDIG: begin
          logic took;
          took = 1'b1;
          unique case (mode)
            MODE_INT: begin
              if (digit) begin
                acc_next = acc_dig;
                if (acc_ovf) sat_next = 1'b1;
              end else if (b == ".") mode_next = MODE_FRAC;
              else if (b == "e" || b == "E") mode_next = MODE_EXPSIGN;
              else took = 1'b0;
            end
            MODE_FRAC: begin
              if (digit) begin
                if (frac >= FRAC_MAX) sat_next = 1'b1;
                else begin
                  acc_next = acc_dig;
                  if (acc_ovf) sat_next = 1'b1;
                  frac_next = frac + 5'd1;
                end
              end else if (b == "e" || b == "E") mode_next = MODE_EXPSIGN;
              else took = 1'b0;
            end
            MODE_EXPSIGN: begin
              if (b == "-") begin
                eneg_next = 1'b1;
                mode_next = MODE_EXPDIG;
              end else if (b == "+") mode_next = MODE_EXPDIG;
              else if (digit) begin
                expa_next = exp_dig;
                mode_next = MODE_EXPDIG;
              end else took = 1'b0;
            end
            default: begin
              if (digit) expa_next = exp_dig;
              else took = 1'b0;
            end
          endcase
          if (took) col_next = col_inc;
          else begin
            p0 = 1'b1;
            t0 = num_tok;
            mode_next = MODE_IDLE;
            idle_go = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          idle_go = 1'b1;
        end
      endcase

      if (idle_go) begin
        token_t it;
        logic ip;
        ip = 1'b0;
        it = '0;
        if (b == 8'd0) begin
          ip = 1'b1;
          it = simple(KIND_END, col, line);
          finish = 1'b1;
        end else if (b == CH_NL) begin
          line_next = line + 16'd1;
          col_next = 16'd0;
        end else if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
          col_next = col_inc;
        end else begin
          tcol_next = col;
          col_next = col_inc;
          if (b == "," || b == "[" || b == "]" || b == "{" || b == "}" || b == ":") begin
            ip = 1'b1;
            it = simple(KIND_DELIM, col, line);
            it.delim = b;
          end else if (b == CH_QUOTE) begin
            mode_next = MODE_STRING;
            esc_next = 1'b0;
          end else if (b == "t") begin
            mode_next = MODE_KW_TRUE;
            kpos_next = 3'd1;
          end else if (b == "f") begin
            mode_next = MODE_KW_FALSE;
            kpos_next = 3'd1;
          end else if (b == "n") begin
            mode_next = MODE_KW_NULL;
            kpos_next = 3'd1;
          end else if (b == "-" || b == "+" || digit) begin
            mode_next = MODE_INT;
            sat_next = 1'b0;
            frac_next = 5'd0;
            expa_next = 10'd0;
            eneg_next = 1'b0;
            neg_next = b == "-";
            acc_next = {59'd0, d};
          end else begin
            ip = 1'b1;
            it = simple(KIND_ERROR, col, line);
            mode_next = MODE_ERROR;
            col_next = col;
          end
        end
        if (ip) begin
          if (p0) begin
            p1 = 1'b1;
            t1 = it;
          end else begin
            p0 = 1'b1;
            t0 = it;
          end
        end
      end
    end

    if (finish) begin
      mode_next = MODE_IDLE;
      acc_next = '0;
      neg_next = 1'b0;
      sat_next = 1'b0;
      frac_next = '0;
      expa_next = '0;
      eneg_next = 1'b0;
      kpos_next = '0;
      esc_next = 1'b0;
      line_next = '0;
      col_next = '0;
      tcol_next = '0;
    end
    if (eoi) begin
      if (p0) begin
        p1 = 1'b1;
        t1 = simple(KIND_END, col, line);
      end else begin
        p0 = 1'b1;
        t0 = simple(KIND_END, col, line);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc <= '0;
      neg <= 1'b0;
      sat <= 1'b0;
      frac <= '0;
      expa <= '0;
      eneg <= 1'b0;
      kpos <= '0;
      esc <= 1'b0;
      line <= '0;
      col <= '0;
      tcol <= '0;
      push0 <= 1'b0;
      push1 <= 1'b0;
    end else begin
      push0 <= step && p0;
      push1 <= step && p1;
      if (step) begin
        mode <= mode_next;
        acc <= acc_next;
        neg <= neg_next;
        sat <= sat_next;
        frac <= frac_next;
        expa <= expa_next;
        eneg <= eneg_next;
        kpos <= kpos_next;
        esc <= esc_next;
        line <= line_next;
        col <= col_next;
        tcol <= tcol_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok0 <= t0;
    tok1 <= t1;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/json_token_scanner_unit.sv =====
// json_token_scanner_unit: top level of the byte-serial json tokenizer
// depends on jts_pkg, jts_scan_core, jts_out_queue
//
// Takes one text byte (or an end-of-input mark) per cycle while in_ready is high
// and emits zero, one or two tokens for it. The scanner state updates once per
// beat; the token registers then feed a four-entry queue, so input is accepted
// every cycle while the queue, counting the tokens still in the token registers,
// has two free entries. Sustained rate is one input beat per cycle as long as the
// output side takes tokens at least as fast as they are made; tokens pass through
// the token registers and then the queue before they appear.
`timescale 1ns / 1ps
`default_nettype none
module json_token_scanner_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   text_byte,
  input  wire logic         end_of_input,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [3:0]        token_kind,
  output logic [7:0]        delimiter_char,
  output logic signed [63:0] number_value,
  output logic [4:0]        fraction_digits,
  output logic signed [10:0] exponent_value,
  output logic [7:0]        string_char,
  output logic [15:0]       line_number,
  output logic [15:0]       column_number,
  output logic              value_overflow
);
  import jts_pkg::*;

  logic   room;
  logic   step;
  logic   push0, push1;
  token_t tok0, tok1, qtok;

  assign in_ready = room;
  assign step = in_valid && in_ready;

  jts_scan_core u_core (
    .clk(clk), .rst(rst), .step(step), .b(text_byte), .eoi(end_of_input),
    .push0(push0), .push1(push1), .tok0(tok0), .tok1(tok1)
  );

  jts_out_queue u_queue (
    .clk(clk), .rst(rst), .push0(push0), .push1(push1), .tok0(tok0), .tok1(tok1),
    .room(room), .out_valid(out_valid), .out_tok(qtok), .out_ready(out_ready)
  );

  assign token_kind = qtok.kind;
  assign delimiter_char = qtok.delim;
  assign number_value = qtok.value;
  assign fraction_digits = qtok.frac;
  assign exponent_value = qtok.expo;
  assign string_char = qtok.ch;
  assign line_number = qtok.line;
  assign column_number = qtok.col;
  assign value_overflow = qtok.ovf;
endmodule
`default_nettype wire

// ===== hw/rtl/json_token_scanner_unit_checker.sv =====
// json_token_scanner_unit_checker: port-level assertions for the tokenizer
// depends on jts_pkg and json_token_scanner_unit
`timescale 1ns / 1ps
`default_nettype none
module json_token_scanner_unit_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] token_kind,
  input wire logic [7:0] delimiter_char,
  input wire logic [4:0] fraction_digits
);
  import jts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("token dropped while stalled");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= KIND_NULL)
    else $error("token kind out of range");
  a_delim_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_DELIM |-> delimiter_char == 8'd0)
    else $error("delimiter char on non-delimiter");
  a_frac_float: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_FLOAT |-> fraction_digits == 5'd0)
    else $error("fraction digits on non-float");
  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
endmodule

bind json_token_scanner_unit json_token_scanner_unit_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
  .delimiter_char(delimiter_char), .fraction_digits(fraction_digits)
);
`default_nettype wire

// ===== tb/tb_json_token_scanner_unit.sv =====
// tb_json_token_scanner_unit: self-checking testbench of the json token scanner
// predicts tokens byte by byte and checks every output beat in order
// depends on jts_pkg and json_token_scanner_unit
`timescale 1ns / 1ps
`default_nettype none
module tb_json_token_scanner_unit;
  import jts_pkg::*;

  class token_scoreboard;
    token_t pending[$];
    int errors;
    int checked;

    // predictor state
    mode_t mode;
    logic [63:0] mag;
    logic neg, sat;
    logic [4:0] fcnt;
    logic [9:0] ecnt;
    logic eneg;
    logic [2:0] kpos;
    logic esc;
    logic [15:0] line, col, tcol;

    function new();
      errors = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_IDLE; mag = 64'd0; neg = 1'b0; sat = 1'b0; fcnt = 5'd0; ecnt = 10'd0;
      eneg = 1'b0; kpos = 3'd0; esc = 1'b0; line = 16'd0; col = 16'd0; tcol = 16'd0;
    endfunction

    function void push(kind_t k, logic [7:0] d, logic [63:0] v, logic [4:0] f,
                       logic [10:0] e, logic [7:0] c, logic [15:0] cl, logic o);
      token_t t;
      t.kind = k; t.delim = d; t.value = v; t.frac = f; t.expo = e; t.ch = c;
      t.line = line; t.col = cl; t.ovf = o;
      pending.push_back(t);
    endfunction

    function void simple(kind_t k, logic [15:0] cl);
      push(k, 8'd0, 64'd0, 5'd0, 11'd0, 8'd0, cl, 1'b0);
    endfunction

    function void step_col();
      if (col != COL_MAX) col++;
    endfunction

    function void finish_doc();
      simple(KIND_END, col);
      clear();
    endfunction

    function void emit_num();
      logic [63:0] v;
      logic [10:0] e;
      v = neg ? -mag : mag;
      e = eneg ? -{1'b0, ecnt} : {1'b0, ecnt};
      if (mode == MODE_INT) push(KIND_INT, 8'd0, v, 5'd0, 11'd0, 8'd0, tcol, sat);
      else push(KIND_FLOAT, 8'd0, v, fcnt, e, 8'd0, tcol, sat);
    endfunction

    function void add_mant(logic [3:0] d);
      if (mag > ({1'b0, MAG_MAX} - d) / 10) begin
        mag = {1'b0, MAG_MAX}; sat = 1'b1;
      end else mag = 64'(mag * 10 + d);
    endfunction

    function void add_exp(logic [3:0] d);
      if (ecnt > (EXP_MAX - d) / 10) ecnt = EXP_MAX;
      else ecnt = 10'(ecnt * 10 + d);
    endfunction

    function bit num_take(logic [7:0] b);
      bit dig;
      logic [3:0] d;
      dig = (b >= "0" && b <= "9");
      d = dig ? 4'(b - "0") : 4'd0;
      case (mode)
        MODE_INT: begin
          if (dig) begin add_mant(d); return 1; end
          if (b == ".") begin mode = MODE_FRAC; return 1; end
          if (b == "e" || b == "E") begin mode = MODE_EXPSIGN; return 1; end
          return 0;
        end
        MODE_FRAC: begin
          if (dig) begin
            if (fcnt >= FRAC_MAX) sat = 1'b1;
            else begin add_mant(d); fcnt++; end
            return 1;
          end
          if (b == "e" || b == "E") begin mode = MODE_EXPSIGN; return 1; end
          return 0;
        end
        MODE_EXPSIGN: begin
          if (b == "-") begin eneg = 1'b1; mode = MODE_EXPDIG; return 1; end
          if (b == "+") begin mode = MODE_EXPDIG; return 1; end
          if (dig) begin add_exp(d); mode = MODE_EXPDIG; return 1; end
          return 0;
        end
        default: begin
          if (dig) begin add_exp(d); return 1; end
          return 0;
        end
      endcase
    endfunction

    function void between_tokens(logic [7:0] b);
      if (b == 8'd0) begin finish_doc(); return; end
      if (b == CH_NL) begin line++; col = 16'd0; return; end
      if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin step_col(); return; end
      tcol = col;
      case (b)
        ",", "[", "]", "{", "}", ":":
          push(KIND_DELIM, b, 64'd0, 5'd0, 11'd0, 8'd0, col, 1'b0);
        CH_QUOTE: begin mode = MODE_STRING; esc = 1'b0; end
        "t": begin mode = MODE_KW_TRUE; kpos = 3'd1; end
        "f": begin mode = MODE_KW_FALSE; kpos = 3'd1; end
        "n": begin mode = MODE_KW_NULL; kpos = 3'd1; end
        default: begin
          if (b == "-" || b == "+" || (b >= "0" && b <= "9")) begin
            mode = MODE_INT; mag = 64'd0; sat = 1'b0; fcnt = 5'd0; ecnt = 10'd0;
            eneg = 1'b0;
            neg = (b == "-");
            if (b >= "0" && b <= "9") add_mant(4'(b - "0"));
          end else begin
            simple(KIND_ERROR, col);
            mode = MODE_ERROR;
            return;
          end
        end
      endcase
      step_col();
    endfunction

    function logic [7:0] word_char(mode_t m, logic [2:0] p);
      string w;
      w = (m == MODE_KW_TRUE) ? "true" : (m == MODE_KW_FALSE) ? "false" : "null";
      return (p < w.len()) ? w[p] : 8'h00;
    endfunction

    function void note_input(logic [7:0] b, logic eoi);
      logic [2:0] len;
      kind_t k;
      if (eoi) begin
        if (mode >= MODE_INT && mode <= MODE_EXPDIG) emit_num();
        else if (mode != MODE_IDLE && mode != MODE_ERROR) simple(KIND_ERROR, col);
        finish_doc();
        return;
      end
      case (mode)
        MODE_STRING: begin
          if (esc) begin
            esc = 1'b0;
            push(KIND_SBYTE, 8'd0, 64'd0, 5'd0, 11'd0, b, tcol, 1'b0);
            step_col();
          end else if (b == CH_QUOTE) begin
            simple(KIND_SEND, tcol);
            mode = MODE_IDLE;
            step_col();
          end else if (b == CH_NL || b == 8'd0) begin
            simple(KIND_ERROR, col);
            mode = MODE_ERROR;
          end else begin
            if (b == CH_BSLASH) esc = 1'b1;
            push(KIND_SBYTE, 8'd0, 64'd0, 5'd0, 11'd0, b, tcol, 1'b0);
            step_col();
          end
        end
        MODE_KW_TRUE, MODE_KW_FALSE, MODE_KW_NULL: begin
          len = (mode == MODE_KW_FALSE) ? 3'd5 : 3'd4;
          k = (mode == MODE_KW_TRUE) ? KIND_TRUE :
              (mode == MODE_KW_FALSE) ? KIND_FALSE : KIND_NULL;
          if (kpos < len && b == word_char(mode, kpos)) begin
            kpos++;
            step_col();
            if (kpos >= len) begin
              simple(k, tcol);
              mode = MODE_IDLE;
              kpos = 3'd0;
            end
          end else begin
            simple(KIND_ERROR, col);
            mode = MODE_ERROR;
            kpos = 3'd0;
            if (b == 8'd0) finish_doc();
          end
        end
        MODE_ERROR: if (b == 8'd0) finish_doc();
        MODE_INT, MODE_FRAC, MODE_EXPSIGN, MODE_EXPDIG: begin
          if (num_take(b)) step_col();
          else begin
            emit_num();
            mode = MODE_IDLE;
            between_tokens(b);
          end
        end
        default: begin
          mode = MODE_IDLE;
          between_tokens(b);
        end
      endcase
    endfunction

    function void check_token(token_t got);
      token_t exp_t;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, actual %p", $realtime, got);
        return;
      end
      exp_t = pending.pop_front();
      if (got !== exp_t) begin
        errors++;
        $display("%0t: token mismatch, expected %p actual %p", $realtime, exp_t, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [7:0] text_byte = 0;
  logic end_of_input = 0;
  wire in_ready, out_valid;
  wire [3:0] token_kind;
  wire [7:0] delimiter_char, string_char;
  wire signed [63:0] number_value;
  wire [4:0] fraction_digits;
  wire signed [10:0] exponent_value;
  wire [15:0] line_number, column_number;
  wire value_overflow;

  json_token_scanner_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .delimiter_char(delimiter_char),
    .number_value(number_value), .fraction_digits(fraction_digits),
    .exponent_value(exponent_value), .string_char(string_char),
    .line_number(line_number), .column_number(column_number),
    .value_overflow(value_overflow)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  token_scoreboard sb = new();
  int idle_cycles = 0;
  int beats_in = 0;
  int gap_max = 0;
  bit hold_off = 0;

  // output side: accepted beats checked, random stalls with always-ready stretches, one long hold-off
  always @(posedge clk) begin
    token_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = token_kind; got.delim = delimiter_char; got.value = number_value;
      got.frac = fraction_digits; got.expo = exponent_value; got.ch = string_char;
      got.line = line_number; got.col = column_number; got.ovf = value_overflow;
      sb.check_token(got);
    end
    if (hold_off) out_ready <= 0;
    else if ((beats_in / 200) % 3 == 1) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("** json_token_scanner_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    in_valid <= 1;
    text_byte <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, eoi);
    beats_in++;
    if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // well-formed fragments with random content, some noise
  task automatic random_piece();
    int sel;
    string s;
    sel = $urandom_range(0, 15);
    s = "";
    case (sel)
      0: s = "true";
      1: s = "false";
      2: s = "null";
      3: begin
        s = "\"";
        repeat ($urandom_range(0, 6)) begin
          byte unsigned c;
          c = $urandom_range(1, 255);
          if (c == CH_NL && $urandom_range(0, 3) != 0) c = "a";
          s = {s, string'(c)};
          if (c == CH_BSLASH) s = {s, string'(byte'($urandom_range(1, 255)))};
        end
        s = {s, "\""};
      end
      4, 5: begin
        if ($urandom_range(0, 1)) s = $urandom_range(0, 1) ? "-" : "+";
        repeat ($urandom_range(0, 22)) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 1)) begin
          s = {s, "."};
          repeat ($urandom_range(0, 35)) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        end
        if ($urandom_range(0, 1)) begin
          s = {s, $urandom_range(0, 1) ? "e" : "E"};
          case ($urandom_range(0, 2))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
          endcase
          repeat ($urandom_range(0, 5)) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        end
        if (s.len() == 0) s = "7";
      end
      6: s = ",";
      7: s = "[";
      8: s = "]";
      9: s = "{";
      10: s = "}";
      11: s = ":";
      12: s = $urandom_range(0, 1) ? " \t" : "\n\r";
      13: s = $urandom_range(0, 1) ? "tru" : "nul";
      14: s = string'(byte'($urandom_range(1, 255)));
      default: s = " ";
    endcase
    send_text(s);
    if ($urandom_range(0, 3) == 0) send_beat(" ", 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send_text("{\"a\\\"\":[-12,3.25e-7,true,false,null]}");
    send_beat(8'h00, 1'b0);
    send_text("9223372036854775808 1.");
    send_text("00000000000000000000000000000000001e99999");
    send_beat(8'h00, 1'b1);
    send_text("-.e+ \"x\ny");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text("\"\\");
    send_beat(8'h00, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_text("fals");
    send_beat(8'h00, 1'b1);
    send_text("tr");
    send_beat(8'h00, 1'b0);
    drain();

    // long receiver hold-off while the sender keeps offering beats
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      repeat (40) random_piece();
    join
    drain();
    send_beat(8'h00, 1'b1);
    drain();

    while (beats_in < 1700) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat ($urandom_range(5, 30)) random_piece();
      if ($urandom_range(0, 5) == 0) send_beat(8'h00, $urandom_range(0, 1));
    end
    send_beat(8'h00, 1'b1);
    drain();
    repeat (20) @(posedge clk);

    $display("fed %0d input beats, checked %0d tokens", beats_in, sb.checked);
    $display("covered strings, escapes, keywords, numbers, errors and stalls");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** json_token_scanner_unit: PASSED **");
    else
      $display("** json_token_scanner_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
